FILE: rtl/hex_record_loader_core_assert.svh
// ----------------------------------------------------------------------------
// hex record loader assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LOADER_CORE_ASSERT_SVH
`define HEX_RECORD_LOADER_CORE_ASSERT_SVH

// same-cycle implication
`define HRL_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hrl assertion failed");

// next-cycle implication
`define HRL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hrl assertion failed");

`endif

FILE: rtl/hrl_pkg.sv
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types, codes and control/status bundles of the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package hrl_pkg;

  localparam int MAX_RECORD_BYTES_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EEPROM_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EEPROM_SIZE = 3'd4;

  // record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_EXT  = 8'h04;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_EOF    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LEN      = 3'd1,
    ERR_CSUM     = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_BAD_CHAR = 3'd4,
    ERR_TOO_LONG = 3'd5
  } err_t;

  // controller to datapath
  typedef struct packed {
    logic  cap_char;
    logic  start_rec;
    logic  set_nibble;
    logic  take_byte;
    logic  end_rec;
    logic  set_upper;
    logic  halt_err;
    logic  halt_eof;
    logic  calc_base;
    logic  calc_hits;
    logic  ld_write;
    logic  adv_write;
    logic  ld_stat;
    kind_t stat_kind;
    err_t  stat_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic in_rec;
    logic is_ws;
    logic is_colon;
    logic is_hex;
    logic excess;
    logic odd;
    logic idx_zero;
    logic len_big;
    logic count_ok;
    logic sum_zero;
    logic type_data;
    logic type_eof;
    logic type_ext;
    logic len_zero;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/hrl_dpath.sv
// ----------------------------------------------------------------------------
// hrl_dpath
// Record registers, checksum, record buffer, region tests and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_dpath #(
  parameter int MAX_RECORD_BYTES = hrl_pkg::MAX_RECORD_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_character,
  input  wire logic                          cfg_we,
  input  wire logic [hrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hrl_pkg::REG_W-1:0]     cfg_data,
  input  wire hrl_pkg::cmd_t                 cmd,
  output hrl_pkg::sts_t                      sts,
  output logic [1:0]                         out_kind,
  output logic [2:0]                         out_error_code,
  output logic [7:0]                         out_byte_value,
  output logic                               out_code_hit,
  output logic [31:0]                        out_code_offset,
  output logic                               out_config_hit,
  output logic [31:0]                        out_config_offset,
  output logic                               out_eeprom_hit,
  output logic [31:0]                        out_eeprom_offset,
  output logic                               out_last
);
  import hrl_pkg::*;

  localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

  // configuration
  logic [31:0] code_size_r, config_base_r, config_size_r, eeprom_base_r, eeprom_size_r;

  // record state
  logic        phase_r;
  logic [1:0]  halted_r;
  logic [8:0]  char_count_r;
  logic [3:0]  high_nibble_r;
  logic [7:0]  rec_len_r;
  logic [15:0] rec_addr_r;
  logic [7:0]  rec_type_r;
  logic [7:0]  sum_r;
  logic [31:0] upper_r;
  logic [7:0]  b0_r, b1_r;
  logic [7:0]  char_r;

  // emission
  logic [31:0]  base_r;
  logic [AW-1:0] emit_idx_r;
  logic         code_hit_r, cfg_hit_r, eep_hit_r;
  logic [31:0]  code_off_r, cfg_off_r, eep_off_r;

  logic [7:0] mem [MAX_RECORD_BYTES];
  logic [7:0] rdata_r;

  // result register
  kind_t       kind_r;
  err_t        err_r;
  logic [7:0]  byte_r;
  logic        o_ch_r, o_fh_r, o_eh_r, last_r;
  logic [31:0] o_co_r, o_fo_r, o_eo_r;

  // character decode
  logic       is_hex;
  logic [3:0] nib;
  logic [7:0] byte_val;
  logic [7:0] idx;
  logic [7:0] didx;
  logic [9:0] expected;
  logic       mem_we;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (char_r >= 8'h30 && char_r <= 8'h39) begin
      nib = 4'(char_r - 8'h30);
    end else if (char_r >= 8'h41 && char_r <= 8'h46) begin
      nib = 4'(char_r - 8'h37);
    end else if (char_r >= 8'h61 && char_r <= 8'h66) begin
      nib = 4'(char_r - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign byte_val = {high_nibble_r, nib};
  assign idx      = char_count_r[8:1];
  assign didx     = idx - 8'd4;
  assign expected = {1'b0, rec_len_r, 1'b0} + 10'd10;
  assign mem_we   = cmd.take_byte && (idx >= 8'd4) && (didx < rec_len_r);

  always_comb begin
    sts.halted    = (halted_r != 2'd0);
    sts.in_rec    = phase_r;
    sts.is_ws     = (char_r == 8'h20) || (char_r >= 8'h09 && char_r <= 8'h0d);
    sts.is_colon  = (char_r == 8'h3a);
    sts.is_hex    = is_hex;
    sts.excess    = (char_count_r >= 9'd2) && ({1'b0, char_count_r} >= expected);
    sts.odd       = char_count_r[0];
    sts.idx_zero  = (idx == 8'd0);
    sts.len_big   = (byte_val > 8'(MAX_RECORD_BYTES));
    sts.count_ok  = ({1'b0, char_count_r} == expected);
    sts.sum_zero  = (sum_r == 8'd0);
    sts.type_data = (rec_type_r == REC_DATA);
    sts.type_eof  = (rec_type_r == REC_EOF);
    sts.type_ext  = (rec_type_r == REC_EXT);
    sts.len_zero  = (rec_len_r == 8'd0);
    sts.emit_last = ((8'(emit_idx_r) + 8'd1) == rec_len_r);
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_size_r   <= '0;
      config_base_r <= '0;
      config_size_r <= '0;
      eeprom_base_r <= '0;
      eeprom_size_r <= '0;
      phase_r       <= 1'b0;
      halted_r      <= 2'd0;
      char_count_r  <= '0;
      upper_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CODE_SIZE:   code_size_r   <= cfg_data;
          REG_CONFIG_BASE: config_base_r <= cfg_data;
          REG_CONFIG_SIZE: config_size_r <= cfg_data;
          REG_EEPROM_BASE: eeprom_base_r <= cfg_data;
          REG_EEPROM_SIZE: eeprom_size_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start_rec) begin
        phase_r      <= 1'b1;
        char_count_r <= '0;
      end
      if (cmd.set_nibble || cmd.take_byte) begin
        char_count_r <= char_count_r + 9'd1;
      end
      if (cmd.end_rec || cmd.halt_err) begin
        phase_r <= 1'b0;
      end
      if (cmd.halt_err) begin
        halted_r <= 2'd1;
      end else if (cmd.halt_eof) begin
        halted_r <= 2'd2;
      end
      if (cmd.set_upper) begin
        upper_r <= {b0_r, b1_r, 16'h0000};
      end
    end
  end

  // record fields
  always_ff @(posedge clk) begin
    if (cmd.cap_char) begin
      char_r <= in_character;
    end
    if (cmd.start_rec) begin
      high_nibble_r <= '0;
      rec_len_r     <= '0;
      rec_addr_r    <= '0;
      rec_type_r    <= '0;
      sum_r         <= '0;
      b0_r          <= '0;
      b1_r          <= '0;
    end
    if (cmd.set_nibble) begin
      high_nibble_r <= nib;
    end
    if (cmd.take_byte) begin
      sum_r <= sum_r + byte_val;
      case (idx)
        8'd0:    rec_len_r <= byte_val;
        8'd1:    rec_addr_r[15:8] <= byte_val;
        8'd2:    rec_addr_r[7:0] <= byte_val;
        8'd3:    rec_type_r <= byte_val;
        default: begin
          if (didx < rec_len_r) begin
            if (didx == 8'd0) b0_r <= byte_val;
            if (didx == 8'd1) b1_r <= byte_val;
          end
        end
      endcase
    end
  end

  // record buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[didx[AW-1:0]] <= byte_val;
    end
    rdata_r <= mem[emit_idx_r];
  end

  // base address, region tests and running offsets
  always_ff @(posedge clk) begin
    if (cmd.calc_base) begin
      base_r     <= upper_r + {16'h0000, rec_addr_r};
      emit_idx_r <= '0;
    end
    if (cmd.calc_hits) begin
      code_hit_r <= base_r < code_size_r;
      cfg_hit_r  <= (base_r >= config_base_r) &&
                    ({1'b0, base_r} < ({1'b0, config_base_r} + {1'b0, config_size_r}));
      eep_hit_r  <= (base_r >= eeprom_base_r) &&
                    ({1'b0, base_r} < ({1'b0, eeprom_base_r} + {1'b0, eeprom_size_r}));
      code_off_r <= base_r;
      cfg_off_r  <= base_r - config_base_r;
      eep_off_r  <= base_r - eeprom_base_r;
    end
    if (cmd.adv_write) begin
      emit_idx_r <= emit_idx_r + AW'(1);
      code_off_r <= code_off_r + 32'd1;
      cfg_off_r  <= cfg_off_r + 32'd1;
      eep_off_r  <= eep_off_r + 32'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_write) begin
      kind_r <= KIND_WRITE;
      err_r  <= ERR_NONE;
      byte_r <= rdata_r;
      o_ch_r <= code_hit_r;
      o_fh_r <= cfg_hit_r;
      o_eh_r <= eep_hit_r;
      o_co_r <= code_hit_r ? code_off_r : 32'd0;
      o_fo_r <= cfg_hit_r ? cfg_off_r : 32'd0;
      o_eo_r <= eep_hit_r ? eep_off_r : 32'd0;
      last_r <= 1'b0;
    end else if (cmd.ld_stat) begin
      kind_r <= cmd.stat_kind;
      err_r  <= cmd.stat_err;
      byte_r <= '0;
      o_ch_r <= 1'b0;
      o_fh_r <= 1'b0;
      o_eh_r <= 1'b0;
      o_co_r <= '0;
      o_fo_r <= '0;
      o_eo_r <= '0;
      last_r <= 1'b1;
    end
  end

  assign out_kind          = kind_r;
  assign out_error_code    = err_r;
  assign out_byte_value    = byte_r;
  assign out_code_hit      = o_ch_r;
  assign out_code_offset   = o_co_r;
  assign out_config_hit    = o_fh_r;
  assign out_config_offset = o_fo_r;
  assign out_eeprom_hit    = o_eh_r;
  assign out_eeprom_offset = o_eo_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

FILE: rtl/hrl_ctrl.sv
// ----------------------------------------------------------------------------
// hrl_ctrl
// Sequencer: per-word decode, end-of-record checks and result draining.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hex_record_loader_core_assert.svh"

module hrl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire hrl_pkg::sts_t sts,
  output hrl_pkg::cmd_t      cmd
);
  import hrl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_BASE   = 10'b0000001000,
    S_HITS   = 10'b0000010000,
    S_READ   = 10'b0000100000,
    S_LOADW  = 10'b0001000000,
    S_SENDW  = 10'b0010000000,
    S_LOADA  = 10'b0100000000,
    S_SENDL  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fail;
  err_t   fail_err;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    fail      = 1'b0;
    fail_err  = ERR_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_char = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (sts.halted) begin
          state_nxt = S_IDLE;
        end else if (!sts.in_rec) begin
          if (sts.is_colon) begin
            cmd.start_rec = 1'b1;
          end else if (!sts.is_ws) begin
            fail     = 1'b1;
            fail_err = ERR_BAD_CHAR;
          end
        end else if (sts.is_ws) begin
          state_nxt = S_CHECK;
        end else if (!sts.is_hex) begin
          fail     = 1'b1;
          fail_err = ERR_BAD_CHAR;
        end else if (sts.excess) begin
          fail     = 1'b1;
          fail_err = ERR_LEN;
        end else if (!sts.odd) begin
          cmd.set_nibble = 1'b1;
        end else begin
          cmd.take_byte = 1'b1;
          // length byte above the buffer size
          if (sts.idx_zero && sts.len_big) begin
            fail     = 1'b1;
            fail_err = ERR_TOO_LONG;
          end
        end
      end
      S_CHECK: begin
        cmd.end_rec = 1'b1;
        if (!sts.count_ok) begin
          fail     = 1'b1;
          fail_err = ERR_LEN;
        end else if (!sts.sum_zero) begin
          fail     = 1'b1;
          fail_err = ERR_CSUM;
        end else if (sts.type_data) begin
          state_nxt = S_BASE;
        end else if (sts.type_ext) begin
          cmd.set_upper = 1'b1;
          cmd.ld_stat   = 1'b1;
          cmd.stat_kind = KIND_ACCEPT;
          cmd.stat_err  = ERR_NONE;
          state_nxt     = S_SENDL;
        end else if (sts.type_eof) begin
          cmd.halt_eof  = 1'b1;
          cmd.ld_stat   = 1'b1;
          cmd.stat_kind = KIND_EOF;
          cmd.stat_err  = ERR_NONE;
          state_nxt     = S_SENDL;
        end else begin
          fail     = 1'b1;
          fail_err = ERR_TYPE;
        end
      end
      S_BASE: begin
        cmd.calc_base = 1'b1;
        state_nxt     = S_HITS;
      end
      S_HITS: begin
        // buffer read of entry zero is issued here
        cmd.calc_hits = 1'b1;
        state_nxt     = sts.len_zero ? S_LOADA : S_LOADW;
      end
      S_READ: begin
        state_nxt = S_LOADW;
      end
      S_LOADW: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_SENDW;
      end
      S_SENDW: begin
        if (out_ready) begin
          cmd.adv_write = 1'b1;
          state_nxt     = sts.emit_last ? S_LOADA : S_READ;
        end
      end
      S_LOADA: begin
        cmd.ld_stat   = 1'b1;
        cmd.stat_kind = KIND_ACCEPT;
        cmd.stat_err  = ERR_NONE;
        state_nxt     = S_SENDL;
      end
      S_SENDL: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fail) begin
      cmd.halt_err  = 1'b1;
      cmd.ld_stat   = 1'b1;
      cmd.stat_kind = KIND_ERROR;
      cmd.stat_err  = fail_err;
      state_nxt     = S_SENDL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SENDW) || (state_r == S_SENDL);

  `HRL_ASSERT_NEXT(a_write_loaded, cmd.ld_write, state_r == S_SENDW)
  `HRL_ASSERT_IMPLY(a_len_check, state_r == S_CHECK && !sts.count_ok, cmd.ld_stat && cmd.stat_err == ERR_LEN)
  `HRL_ASSERT_NEXT(a_halted_quiet, state_r == S_DECODE && sts.halted, state_r == S_IDLE)
  `HRL_ASSERT_IMPLY(a_single_load, cmd.ld_write, !cmd.ld_stat)

endmodule

`default_nettype wire

FILE: rtl/hex_record_loader_core.sv
// Sequence: a word that yields no result frees the input after its decode step; an error on a
// digit or stray character is loaded by the decode step, a record-end result (check error, end
// of file, address) by the check step after the closing blank. A data record computes its base
// address and region hits, then gives each write by buffer read, result load and handshake, and
// the accept word after the last handshake. Input is taken only once the previous word is done.
// Reset: synchronous active-low, clears the configuration, control and sequencer state only.
// ----------------------------------------------------------------------------
// hex_record_loader_core
// Intel HEX text parser with region mapping of data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_loader_core #(
  parameter int MAX_RECORD_BYTES = hrl_pkg::MAX_RECORD_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_character,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_kind,
  output logic [2:0]                         out_error_code,
  output logic [7:0]                         out_byte_value,
  output logic                               out_code_hit,
  output logic [31:0]                        out_code_offset,
  output logic                               out_config_hit,
  output logic [31:0]                        out_config_offset,
  output logic                               out_eeprom_hit,
  output logic [31:0]                        out_eeprom_offset,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hrl_pkg::REG_W-1:0]     cfg_data
);
  import hrl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hrl_dpath #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_character      (in_character),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_kind          (out_kind),
    .out_error_code    (out_error_code),
    .out_byte_value    (out_byte_value),
    .out_code_hit      (out_code_hit),
    .out_code_offset   (out_code_offset),
    .out_config_hit    (out_config_hit),
    .out_config_offset (out_config_offset),
    .out_eeprom_hit    (out_eeprom_hit),
    .out_eeprom_offset (out_eeprom_offset),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
